@@ sv/assert_macros.svh @@
// Assertion macros for the interval cover tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge, reset excluded.
`define CHK_IMPL(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("check failed");
// Next-cycle implication, reset excluded.
`define CHK_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("check failed");
`endif

@@ sv/ict_pkg.sv @@
// Package for the interval cover tracker: sizes, types and states.
package ict_pkg;
  localparam int TableDepth = 64;
  localparam int CoordBits = 24;
  localparam int IdxBits = $clog2(TableDepth);
  localparam int CntBits = $clog2(TableDepth + 1);
  localparam int TotBits = 20;
  localparam logic [TotBits-1:0] CounterMax = '1;

  typedef struct packed {
    logic [CoordBits-1:0] left_edge;
    logic [CoordBits-1:0] right_edge;
  } in_req_t;

  typedef struct packed {
    logic newly_visible;
    logic [TotBits-1:0] visible_total;
    logic table_overflow;
  } out_req_t;

  typedef struct packed {
    logic [CoordBits-1:0] first;
    logic [CoordBits-1:0] last;
  } range_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH_RD, S_SRCH, S_MRG_RD, S_MRG, S_DECIDE,
    S_SHR_RD, S_SHR_WR, S_SHL_RD, S_SHL_WR, S_OUT
  } state_t;
endpackage

@@ sv/ict_ram.sv @@
// Single-port-write, one-read synchronous RAM holding the range table.
module ict_ram import ict_pkg::*; (
  input  logic               clk,
  input  logic               we,
  input  logic [IdxBits-1:0] waddr,
  input  range_t             wdata,
  input  logic [IdxBits-1:0] raddr,
  output range_t             rdata
);
  range_t mem [TableDepth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ sv/interval_cover_tracker.sv @@
// Top level of the interval cover tracker: sequencer around the range table RAM.
//   channel | dir | handshake            | payload
//   in      | in  | in_valid / in_ready  | in_req_t
//   out     | out | out_valid / out_ready| out_req_t
// One request at a time; a result follows the search, merge and any shift of the table.
// Scans and insert or close-up shifts go one entry at a time over the RAM port.
// A result waits in the output register; the next request is taken once it is taken.
// Synchronous reset clears count, counter and state; the table needs no clearing.
`include "assert_macros.svh"
module interval_cover_tracker import ict_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_req_t out_data
);
  state_t state, state_next;
  logic [CntBits-1:0] count, count_next;
  logic [TotBits-1:0] total, total_next;
  logic [CntBits-1:0] ii, ii_next, jj, jj_next, kk, kk_next;
  logic [CoordBits:0] lo, lo_next, hi, hi_next;
  logic vis, vis_next, ovf, ovf_next;
  logic out_valid_next;

  logic we;
  logic [IdxBits-1:0] waddr, raddr;
  range_t wdata, rdata;

  ict_ram u_ram (.clk, .we, .waddr, .wdata, .raddr, .rdata);

  logic [CoordBits:0] r_first, r_last;
  assign r_first = {1'b0, rdata.first};
  assign r_last  = {1'b0, rdata.last};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      total <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      total <= total_next;
      out_valid <= out_valid_next;
    end
    ii <= ii_next; jj <= jj_next; kk <= kk_next;
    lo <= lo_next; hi <= hi_next; vis <= vis_next; ovf <= ovf_next;
  end

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign out_data.newly_visible = vis;
  assign out_data.visible_total = total;
  assign out_data.table_overflow = ovf;

  always_comb begin
    state_next = state;
    count_next = count; total_next = total;
    ii_next = ii; jj_next = jj; kk_next = kk;
    lo_next = lo; hi_next = hi; vis_next = vis; ovf_next = ovf;
    out_valid_next = out_valid && !out_ready;
    we = 1'b0; waddr = kk[IdxBits-1:0]; wdata = '0;
    raddr = ii[IdxBits-1:0];
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          lo_next = {1'b0, in_data.left_edge[CoordBits-1:0]} + 1'b1;
          hi_next = {1'b0, in_data.right_edge[CoordBits-1:0]};
          vis_next = 1'b0; ovf_next = 1'b0; ii_next = '0;
          if (in_data.left_edge[CoordBits-1:0] < in_data.right_edge[CoordBits-1:0])
            state_next = S_SRCH_RD;
          else
            state_next = S_OUT;
        end
      end
      S_SRCH_RD: begin
        if (ii < count) state_next = S_SRCH;
        else begin
          vis_next = 1'b1; jj_next = ii; state_next = S_DECIDE;
        end
      end
      S_SRCH: begin
        if (r_last + 1'b1 < lo) begin
          ii_next = ii + 1'b1; state_next = S_SRCH_RD;
        end else if (r_first <= lo && r_last >= hi) begin
          state_next = S_OUT;
        end else begin
          vis_next = 1'b1; jj_next = ii; state_next = S_MRG;
        end
      end
      S_MRG_RD: begin
        raddr = jj[IdxBits-1:0];
        if (jj < count) state_next = S_MRG;
        else state_next = S_DECIDE;
      end
      S_MRG: begin
        raddr = jj[IdxBits-1:0];
        if (r_first <= hi + 1'b1) begin
          if (r_first < lo) lo_next = r_first;
          if (r_last > hi) hi_next = r_last;
          jj_next = jj + 1'b1;
          raddr = jj_next[IdxBits-1:0];
          state_next = S_MRG_RD;
        end else state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (total != CounterMax) total_next = total + 1'b1;
        if (jj == ii) begin
          if (count == CntBits'(TableDepth)) begin
            ovf_next = 1'b1; state_next = S_OUT;
          end else begin
            kk_next = count; state_next = S_SHR_RD;
          end
        end else begin
          we = 1'b1; waddr = ii[IdxBits-1:0];
          wdata.first = lo[CoordBits-1:0]; wdata.last = hi[CoordBits-1:0];
          kk_next = ii + 1'b1; state_next = S_SHL_RD;
        end
      end
      S_SHR_RD: begin
        raddr = kk[IdxBits-1:0] - 1'b1;
        if (kk > ii) state_next = S_SHR_WR;
        else begin
          we = 1'b1; waddr = ii[IdxBits-1:0];
          wdata.first = lo[CoordBits-1:0]; wdata.last = hi[CoordBits-1:0];
          count_next = count + 1'b1; state_next = S_OUT;
        end
      end
      S_SHR_WR: begin
        we = 1'b1; wdata = rdata;
        kk_next = kk - 1'b1; state_next = S_SHR_RD;
      end
      S_SHL_RD: begin
        raddr = jj[IdxBits-1:0];
        if (jj < count) state_next = S_SHL_WR;
        else begin
          count_next = kk; state_next = S_OUT;
        end
      end
      S_SHL_WR: begin
        we = 1'b1; wdata = rdata;
        kk_next = kk + 1'b1; jj_next = jj + 1'b1; state_next = S_SHL_RD;
      end
      S_OUT: begin
        out_valid_next = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  `CHK_IMPL(a_count_bound, clk, rst, 1'b1, count <= CntBits'(TableDepth))
  `CHK_IMPL(a_ovf_vis, clk, rst, out_valid && out_data.table_overflow,
    out_data.newly_visible)
  `CHK_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(total))
endmodule
